[design/ifmc_pkg.sv]
// Shared types and constants of the idle fade mode controller.
package ifmc_pkg;

   // Internal mode register, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE       = 5'b00001,
      ST_WAKE_IDLE  = 5'b00010,
      ST_WAKE_ENTER = 5'b00100,
      ST_AWAKE      = 5'b01000,
      ST_ENTER      = 5'b10000
   } mode_state_type;

   // Mode codes as seen on the result port.
   localparam logic [2:0] MODE_CODE_IDLE       = 3'd0;
   localparam logic [2:0] MODE_CODE_WAKE_IDLE  = 3'd1;
   localparam logic [2:0] MODE_CODE_WAKE_ENTER = 3'd2;
   localparam logic [2:0] MODE_CODE_AWAKE      = 3'd3;
   localparam logic [2:0] MODE_CODE_ENTER      = 3'd4;

   localparam logic [1:0] RATE_NONE       = 2'd0;
   localparam logic [1:0] RATE_UNDERLYING = 2'd1;
   localparam logic [1:0] RATE_FAST       = 2'd2;

   localparam logic [1:0] PHASE_SLASH = 2'd0;
   localparam logic [1:0] PHASE_BLACK = 2'd1;
   localparam logic [1:0] PHASE_OPEN  = 2'd2;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_KEY  = 1'b1;

   localparam logic [2:0] CSR_IDLE_TIMEOUT = 3'd0;
   localparam logic [2:0] CSR_ENTER_IDLE   = 3'd1;
   localparam logic [2:0] CSR_SLASH        = 3'd2;
   localparam logic [2:0] CSR_SHOW_LINE    = 3'd3;
   localparam logic [2:0] CSR_MOVE_LINE    = 3'd4;
   localparam logic [2:0] CSR_STEP_LIMIT   = 3'd5;

   localparam logic [23:0] RST_IDLE_TIMEOUT = 24'd60000;
   localparam logic [15:0] RST_ENTER_IDLE   = 16'd250;
   localparam logic [15:0] RST_SLASH        = 16'd700;
   localparam logic [15:0] RST_SHOW_LINE    = 16'd200;
   localparam logic [15:0] RST_MOVE_LINE    = 16'd450;
   localparam logic [15:0] RST_STEP_LIMIT   = 16'd50;

   localparam logic [15:0] T16_MAX = 16'hFFFF;
   localparam logic [23:0] T24_MAX = 24'hFFFFFF;

   typedef struct packed {
      logic [23:0] idle_timeout_ms;
      logic [15:0] enter_idle_ms;
      logic [15:0] slash_ms;
      logic [15:0] show_line_ms;
      logic [15:0] move_line_ms;
      logic [15:0] wake_step_limit_ms;
   } cfg_type;

   typedef struct packed {
      mode_state_type mode;
      logic [15:0]    mode_timer;
      logic [23:0]    idle_counter;
   } ctx_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        fully_opaque;
      logic        fully_transparent;
      logic [1:0]  rate_mode;
      logic [1:0]  wake_phase;
      logic [15:0] phase_time_ms;
   } result_type;

endpackage

[design/ifmc_csr.sv]
// Configuration register file of the idle fade mode controller.
module ifmc_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [2:0]          wr_index,
   input  logic [23:0]         wr_data,
   output ifmc_pkg::cfg_type   cfg
);
   import ifmc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_IDLE_TIMEOUT: cfg_in.idle_timeout_ms    = wr_data;
            CSR_ENTER_IDLE:   cfg_in.enter_idle_ms      = wr_data[15:0];
            CSR_SLASH:        cfg_in.slash_ms           = wr_data[15:0];
            CSR_SHOW_LINE:    cfg_in.show_line_ms       = wr_data[15:0];
            CSR_MOVE_LINE:    cfg_in.move_line_ms       = wr_data[15:0];
            CSR_STEP_LIMIT:   cfg_in.wake_step_limit_ms = wr_data[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout_ms    <= RST_IDLE_TIMEOUT;
         cfg_ff.enter_idle_ms      <= RST_ENTER_IDLE;
         cfg_ff.slash_ms           <= RST_SLASH;
         cfg_ff.show_line_ms       <= RST_SHOW_LINE;
         cfg_ff.move_line_ms       <= RST_MOVE_LINE;
         cfg_ff.wake_step_limit_ms <= RST_STEP_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/ifmc_step.sv]
// Next mode, timers and result for one tick or key press.
module ifmc_step (
   input  ifmc_pkg::cfg_type    cfg,
   input  ifmc_pkg::ctx_type    ctx,
   input  logic                 operation,
   input  logic [15:0]          elapsed_ms,
   output ifmc_pkg::ctx_type    ctx_next,
   output ifmc_pkg::result_type result
);
   import ifmc_pkg::*;

   logic [15:0] step_ms;
   logic [15:0] up_addend;
   logic [16:0] up_sum;
   logic [15:0] up_sat;
   logic [17:0] wake_sum;
   logic [15:0] wake_end;
   logic [15:0] down_val;
   logic [24:0] idle_sum;
   logic [23:0] idle_sat;
   logic [16:0] black_end;
   logic        crossed;

   // One saturating adder serves both up-counting modes.
   assign step_ms   = (elapsed_ms < cfg.wake_step_limit_ms) ? elapsed_ms
                                                            : cfg.wake_step_limit_ms;
   assign up_addend = (ctx.mode == ST_WAKE_IDLE) ? step_ms : elapsed_ms;
   assign up_sum    = {1'b0, ctx.mode_timer} + {1'b0, up_addend};
   assign up_sat    = up_sum[16] ? T16_MAX : up_sum[15:0];

   assign wake_sum  = {2'b00, cfg.slash_ms} + {2'b00, cfg.show_line_ms}
                    + {2'b00, cfg.move_line_ms};
   assign wake_end  = (wake_sum[17:16] != 2'b00) ? T16_MAX : wake_sum[15:0];

   assign down_val  = (ctx.mode_timer > elapsed_ms) ? (ctx.mode_timer - elapsed_ms)
                                                    : 16'd0;

   assign idle_sum  = {1'b0, ctx.idle_counter} + {9'd0, elapsed_ms};
   assign idle_sat  = idle_sum[24] ? T24_MAX : idle_sum[23:0];
   assign crossed   = (idle_sat >= cfg.idle_timeout_ms)
                   && (ctx.idle_counter < cfg.idle_timeout_ms);

   always_comb begin
      ctx_next = ctx;
      if (operation == OP_KEY) begin
         ctx_next.idle_counter = 24'd0;
         if (ctx.mode == ST_IDLE) begin
            ctx_next.mode       = ST_WAKE_IDLE;
            ctx_next.mode_timer = 16'd0;
         end else if (ctx.mode == ST_ENTER) begin
            // The wipe runs backward from where it stands.
            ctx_next.mode = ST_WAKE_ENTER;
         end
      end else begin
         unique case (ctx.mode)
            ST_WAKE_IDLE: begin
               if (up_sat >= wake_end) begin
                  ctx_next.mode       = ST_AWAKE;
                  ctx_next.mode_timer = 16'd0;
               end else begin
                  ctx_next.mode_timer = up_sat;
               end
            end
            ST_WAKE_ENTER: begin
               ctx_next.mode_timer = down_val;
               if (down_val == 16'd0) ctx_next.mode = ST_AWAKE;
            end
            ST_AWAKE: begin
               ctx_next.idle_counter = idle_sat;
               if (crossed) begin
                  ctx_next.mode       = ST_ENTER;
                  ctx_next.mode_timer = 16'd0;
               end
            end
            ST_ENTER: begin
               if (up_sat >= cfg.enter_idle_ms) begin
                  ctx_next.mode       = ST_IDLE;
                  ctx_next.mode_timer = 16'd0;
               end else begin
                  ctx_next.mode_timer = up_sat;
               end
            end
            default: ctx_next = ctx;
         endcase
      end
   end

   assign black_end = {1'b0, cfg.slash_ms} + {1'b0, cfg.show_line_ms};

   always_comb begin
      result               = '0;
      result.phase_time_ms = ctx_next.mode_timer;
      unique case (ctx_next.mode)
         ST_WAKE_IDLE: begin
            result.mode      = MODE_CODE_WAKE_IDLE;
            result.rate_mode = RATE_FAST;
            if (ctx_next.mode_timer < cfg.slash_ms) begin
               result.wake_phase = PHASE_SLASH;
            end else if ({1'b0, ctx_next.mode_timer} < black_end) begin
               result.wake_phase = PHASE_BLACK;
            end else begin
               result.wake_phase = PHASE_OPEN;
            end
         end
         ST_WAKE_ENTER: begin
            result.mode      = MODE_CODE_WAKE_ENTER;
            result.rate_mode = RATE_FAST;
         end
         ST_AWAKE: begin
            result.mode              = MODE_CODE_AWAKE;
            result.fully_transparent = 1'b1;
            result.rate_mode         = RATE_UNDERLYING;
         end
         ST_ENTER: begin
            result.mode      = MODE_CODE_ENTER;
            result.rate_mode = RATE_FAST;
         end
         default: begin
            result.mode         = MODE_CODE_IDLE;
            result.fully_opaque = 1'b1;
            result.rate_mode    = RATE_NONE;
         end
      endcase
   end

endmodule

[design/idle_fade_mode_controller.sv]
// Top level of the idle fade mode controller: input register, state and result register.
// A taken word waits in the input register until the result register takes it for rsp_.
// Throughput: one word per cycle, limited only by rsp_ready; the step logic is combinational.
// Reset (synchronous, active high) empties both registers, loads the register defaults and
// puts the controller in waking from idle with both timers at zero.
// The configuration port is always ready and takes effect on the next word that is stepped.
module idle_fade_mode_controller (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [15:0] req_elapsed_ms,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_mode,
   output logic        rsp_fully_opaque,
   output logic        rsp_fully_transparent,
   output logic [1:0]  rsp_rate_mode,
   output logic [1:0]  rsp_wake_phase,
   output logic [15:0] rsp_phase_time_ms,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import ifmc_pkg::*;

   cfg_type    cfg;
   ctx_type    ctx_ff;
   ctx_type    ctx_in;
   ctx_type    ctx_next;
   result_type step_result;
   result_type result_ff;
   result_type result_in;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic        in_op_ff;
   logic        in_op_in;
   logic [15:0] in_elapsed_ff;
   logic [15:0] in_elapsed_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic        advance;
   logic        req_take;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;

   ifmc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // The held word is stepped against the current state as it moves into the result
   // register, so the state always reflects every word already delivered or waiting.
   ifmc_step u_step (
      .cfg        (cfg),
      .ctx        (ctx_ff),
      .operation  (in_op_ff),
      .elapsed_ms (in_elapsed_ff),
      .ctx_next   (ctx_next),
      .result     (step_result)
   );

   // The input register moves on whenever the result register is empty or is being
   // drained this cycle; the input register in turn refills in the same cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_op_in      = in_op_ff;
      in_elapsed_in = in_elapsed_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_take) begin
         in_valid_in   = 1'b1;
         in_op_in      = req_operation;
         in_elapsed_in = req_elapsed_ms;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      ctx_in       = ctx_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (advance) begin
         out_valid_in = 1'b1;
         result_in    = step_result;
         ctx_in       = ctx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         ctx_ff.mode         <= ST_WAKE_IDLE;
         ctx_ff.mode_timer   <= 16'd0;
         ctx_ff.idle_counter <= 24'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctx_ff       <= ctx_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_op_ff      <= in_op_in;
      in_elapsed_ff <= in_elapsed_in;
      result_ff     <= result_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_mode              = result_ff.mode;
   assign rsp_fully_opaque      = result_ff.fully_opaque;
   assign rsp_fully_transparent = result_ff.fully_transparent;
   assign rsp_rate_mode         = result_ff.rate_mode;
   assign rsp_wake_phase        = result_ff.wake_phase;
   assign rsp_phase_time_ms     = result_ff.phase_time_ms;

endmodule
